[hw/rtl/etf_pkg.sv]
// etf_pkg: shared types and constants of the escape-time fractal iterator
// holds register indexes, reset values, config struct and ctrl/datapath structs
// no dependencies
`default_nettype none

package etf_pkg;

  localparam int FRACTION_BITS_DEF = 24;
  localparam int COUNT_WIDTH_DEF   = 16;

  localparam int COORD_W    = 32;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int THRESH_W   = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int MAX_ITER_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_REAL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IMAG       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS   = 3'd4;

  localparam logic [THRESH_W-1:0] THRESH_RESET   = 31'd67108864;
  localparam int                  MAX_ITER_RESET = 256;

  typedef struct packed {
    logic                       julia_mode;
    logic signed [COORD_W-1:0]  const_real;
    logic signed [COORD_W-1:0]  const_imag;
    logic        [THRESH_W-1:0] escape_threshold;
  } etf_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } etf_state_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic step;
    logic finish;
  } etf_cmd_t;

  typedef struct packed {
    logic escape_hit;
    logic at_limit;
    logic out_free;
  } etf_status_t;

endpackage

`default_nettype wire

[hw/rtl/etf_if.sv]
// etf_if: valid/ready channel interfaces for points in and results out
// depends on etf_pkg for widths
`default_nettype none

interface etf_point_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [etf_pkg::COORD_W-1:0]     point_real;
  logic signed [etf_pkg::COORD_W-1:0]     point_imag;

  modport source (output valid, output point_real, output point_imag, input ready);
  modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

interface etf_result_if #(
  parameter int COUNT_WIDTH = etf_pkg::COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   escaped;
  logic [COUNT_WIDTH-1:0] iteration_count;

  modport source (output valid, output escaped, output iteration_count, input ready);
  modport sink   (input valid, input escaped, input iteration_count, output ready);
endinterface

`default_nettype wire

[hw/rtl/etf_ctrl.sv]
// etf_ctrl: sequencer for load, multiply and update phases of each item
// depends on etf_pkg for state, command and status types
`default_nettype none

module etf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire etf_pkg::etf_status_t status,
  output logic                      in_ready,
  output etf_pkg::etf_cmd_t         cmd
);
  import etf_pkg::*;

  etf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (status.escape_hit || status.at_limit) begin
          if (status.out_free) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
      end
      ST_UPD: begin
        if (status.escape_hit || status.at_limit) begin
          cmd.finish = status.out_free;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/etf_datapath.sv]
// etf_datapath: z and c registers, squaring products, update, escape test, result register
// depends on etf_pkg; driven by etf_ctrl commands
`default_nettype none

module etf_datapath #(
  parameter int FRACTION_BITS = etf_pkg::FRACTION_BITS_DEF,
  parameter int COUNT_WIDTH   = etf_pkg::COUNT_WIDTH_DEF,
  parameter int KW            = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire etf_pkg::etf_cmd_t                   cmd,
  input  wire etf_pkg::etf_cfg_t                   cfg,
  input  wire logic [KW-1:0]                       max_iter,
  input  wire logic signed [etf_pkg::COORD_W-1:0]  in_point_real,
  input  wire logic signed [etf_pkg::COORD_W-1:0]  in_point_imag,
  input  wire logic                                out_ready,
  output etf_pkg::etf_status_t                     status,
  output logic                                     out_valid,
  output logic                                     out_escaped,
  output logic [COUNT_WIDTH-1:0]                   out_iteration_count
);
  import etf_pkg::*;

  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sd2147483648);

  logic signed [COORD_W-1:0] zr_r, zi_r, cr_r, ci_r;
  logic signed [PROD_W-1:0]  rr_r, ii_r, ri_r;
  logic [KW-1:0]             k_r;
  logic                      out_valid_r;
  logic                      out_escaped_r;
  logic [COUNT_WIDTH-1:0]    out_count_r;

  logic [PROD_W-1:0]         mod2;
  logic [PROD_W-1:0]         limit;
  logic signed [PROD_W-1:0]  diff, re_sum, im_sum;
  logic signed [COORD_W-1:0] zr_nxt, zi_nxt;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > SAT_MAX) begin
      res = COORD_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      res = COORD_W'(SAT_MIN);
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    mod2   = $unsigned(rr_r) + $unsigned(ii_r);
    limit  = PROD_W'(cfg.escape_threshold) << FRACTION_BITS;
    diff   = rr_r - ii_r;
    re_sum = (diff >>> FRACTION_BITS) + PROD_W'(cr_r);
    im_sum = (ri_r >>> (FRACTION_BITS - 1)) + PROD_W'(ci_r);
    zr_nxt = sat32(re_sum);
    zi_nxt = sat32(im_sum);
  end

  always_comb begin
    status.escape_hit = (k_r != '0) && (mod2 > limit);
    status.at_limit   = (k_r == max_iter);
    status.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cfg.julia_mode) begin
        zr_r <= in_point_real;
        zi_r <= in_point_imag;
        cr_r <= cfg.const_real;
        ci_r <= cfg.const_imag;
      end else begin
        zr_r <= '0;
        zi_r <= '0;
        cr_r <= in_point_real;
        ci_r <= in_point_imag;
      end
      k_r <= '0;
    end else if (cmd.step) begin
      zr_r <= zr_nxt;
      zi_r <= zi_nxt;
      k_r  <= k_r + KW'(1);
    end
    if (cmd.mul_en) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    if (cmd.finish) begin
      out_escaped_r <= status.escape_hit;
      out_count_r   <= status.escape_hit ? COUNT_WIDTH'(k_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_escaped         = out_escaped_r;
  assign out_iteration_count = out_count_r;

endmodule

`default_nettype wire

[hw/rtl/escape_time_fractal_iterator_core.sv]
// escape_time_fractal_iterator_core: Mandelbrot/Julia escape-time iterator, Q8.24 points
// each iteration has two steps: product register, then update and escape test on products
// a new item is taken only once the previous one has finished; next item taken while a result waits
// reset: config registers to reset values, sequencer idle, result register empty
// depends on etf_pkg, etf_if, etf_ctrl, etf_datapath
`default_nettype none

module escape_time_fractal_iterator_core #(
  parameter int FRACTION_BITS = etf_pkg::FRACTION_BITS_DEF,
  parameter int COUNT_WIDTH   = etf_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [etf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [etf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  etf_point_if.sink                             in_pt,
  etf_result_if.source                          out_res
);
  import etf_pkg::*;

  localparam int MW = (COUNT_WIDTH < MAX_ITER_W) ? COUNT_WIDTH : MAX_ITER_W;
  localparam int KW = (MW < 9) ? 9 : MW;

  etf_cfg_t    cfg_r, cfg_nxt;
  logic [KW-1:0] max_iter_r, max_iter_nxt;
  etf_cmd_t    cmd;
  etf_status_t status;
  logic        in_ready;

  always_comb begin
    cfg_nxt      = cfg_r;
    max_iter_nxt = max_iter_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_JULIA_MODE:       cfg_nxt.julia_mode       = cfg_wdata[0];
        REG_CONST_REAL:       cfg_nxt.const_real       = cfg_wdata;
        REG_CONST_IMAG:       cfg_nxt.const_imag       = cfg_wdata;
        REG_ESCAPE_THRESHOLD: cfg_nxt.escape_threshold = cfg_wdata[THRESH_W-1:0];
        REG_MAX_ITERATIONS:   max_iter_nxt             = KW'(cfg_wdata[MW-1:0]);
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.julia_mode       <= 1'b0;
      cfg_r.const_real       <= '0;
      cfg_r.const_imag       <= '0;
      cfg_r.escape_threshold <= THRESH_RESET;
      max_iter_r             <= KW'(MAX_ITER_RESET);
    end else begin
      cfg_r      <= cfg_nxt;
      max_iter_r <= max_iter_nxt;
    end
  end

  etf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pt.valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  etf_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .KW            (KW)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg                 (cfg_r),
    .max_iter            (max_iter_r),
    .in_point_real       (in_pt.point_real),
    .in_point_imag       (in_pt.point_imag),
    .out_ready           (out_res.ready),
    .status              (status),
    .out_valid           (out_res.valid),
    .out_escaped         (out_res.escaped),
    .out_iteration_count (out_res.iteration_count)
  );

  assign in_pt.ready = in_ready;

`ifndef ASSERT_OFF
  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> status.out_free)
    else $error("result written over a pending item");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pt.valid && in_pt.ready) |=> !$rose(out_res.valid))
    else $error("result appeared one cycle after accept");

  a_escape_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.escaped) |-> (out_res.iteration_count != '0))
    else $error("escaped item with zero count");

  a_bounded_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.escaped) |-> (out_res.iteration_count == '0))
    else $error("bounded item with nonzero count");
`endif

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench: self-checking bench for the escape-time fractal iterator core
// drives points through valid/ready with random gaps, predicts escape results from its own model
// depends on etf_pkg, etf_if and escape_time_fractal_iterator_core
`timescale 1ns / 100ps

module testbench;
  import etf_pkg::*;

  localparam int FRAC           = FRACTION_BITS_DEF;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_PHASES  = 24;
  localparam int ITEMS_PER_PHASE = 27;
  localparam int PRESSURE_PHASE = 2;
  localparam int TAIL_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 4 * (2 * 65535 + 3 + LONG_HOLD + 250);
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [COORD_W-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_ONE  = 32'sh0100_0000;
  localparam logic signed [COORD_W-1:0] Q_LSB  = 32'sh0000_0001;

  typedef struct packed {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } point_t;

  typedef struct packed {
    logic                  escaped;
    logic [MAX_ITER_W-1:0] count;
  } escape_t;

  typedef struct packed {
    point_t  pt;
    escape_t res;
  } escape_due_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic pt_valid = 1'b0;
  logic signed [COORD_W-1:0] pt_real = '0;
  logic signed [COORD_W-1:0] pt_imag = '0;
  logic res_ready = 1'b0;

  etf_point_if  in_pt ();
  etf_result_if out_res ();

  assign in_pt.valid      = pt_valid;
  assign in_pt.point_real = pt_real;
  assign in_pt.point_imag = pt_imag;
  assign out_res.ready    = res_ready;

  escape_time_fractal_iterator_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_pt    (in_pt),
    .out_res  (out_res)
  );

  // register mirror
  logic                        julia_en = 1'b0;
  logic signed [COORD_W-1:0]   c_real = '0;
  logic signed [COORD_W-1:0]   c_imag = '0;
  logic [THRESH_W-1:0]         threshold = THRESH_RESET;
  logic [MAX_ITER_W-1:0]       iter_limit = MAX_ITER_W'(MAX_ITER_RESET);

  point_t      points_to_send[$];
  escape_due_t escape_results_due[$];
  escape_due_t due;

  bit sender_idle_en = 1'b1;
  bit receiver_idle_en = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned points_checked = 0;
  int unsigned escaped_seen = 0;
  int unsigned bounded_seen = 0;
  int unsigned settings_used = 0;

  initial forever #5 clk = ~clk;

  function automatic longint clamp32(input longint v);
    if (v > longint'(Q_MAX)) return longint'(Q_MAX);
    if (v < longint'(Q_MIN)) return longint'(Q_MIN);
    return v;
  endfunction

  function automatic escape_t predict_escape(input point_t p);
    longint zr, zi, cr, ci, rr, ii, ri;
    logic [63:0] mod2, limit;
    int unsigned n;
    escape_t r;
    r = '0;
    limit = 64'(threshold) << FRAC;
    if (julia_en) begin
      zr = p.re;
      zi = p.im;
      cr = c_real;
      ci = c_imag;
    end else begin
      zr = 0;
      zi = 0;
      cr = p.re;
      ci = p.im;
    end
    n = 1;
    while (!r.escaped && n <= iter_limit) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      zr = clamp32(((rr - ii) >>> FRAC) + cr);
      zi = clamp32((ri >>> (FRAC - 1)) + ci);
      mod2 = zr * zr + zi * zi;
      if (mod2 > limit) begin
        r.escaped = 1'b1;
        r.count = n[MAX_ITER_W-1:0];
      end
      n++;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 250);
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 2 * span) - span;
    if (r < 80) return $urandom();
    if (r < 90) begin
      case ($urandom_range(0, 4))
        0: return Q_MIN;
        1: return Q_MAX;
        2: return '0;
        3: return -Q_LSB;
        default: return Q_LSB;
      endcase
    end
    return $urandom_range(0, 512) - 256;
  endfunction

  function automatic logic [THRESH_W-1:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 60) return THRESH_RESET;
    if (r < 85) return THRESH_W'($urandom_range(0, 32'h1000_0000));
    return THRESH_W'($urandom());
  endfunction

  function automatic logic [MAX_ITER_W-1:0] pick_iterations();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 74) return MAX_ITER_W'($urandom_range(1, 48));
    if (r < 94) return MAX_ITER_W'($urandom_range(49, 256));
    return MAX_ITER_W'($urandom_range(257, 600));
  endfunction

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_JULIA_MODE:       julia_en = data[0];
      REG_CONST_REAL:       c_real = data;
      REG_CONST_IMAG:       c_imag = data;
      REG_ESCAPE_THRESHOLD: threshold = data[THRESH_W-1:0];
      REG_MAX_ITERATIONS:   iter_limit = data[MAX_ITER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_point(input logic signed [COORD_W-1:0] re, input logic signed [COORD_W-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    points_to_send.push_back(p);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (points_to_send.size() != 0 || pt_valid || escape_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // point driver
  always @(posedge clk) begin
    if (!rst_n) begin
      pt_valid <= 1'b0;
      send_gap <= 0;
    end else if (!pt_valid || in_pt.ready) begin
      if (send_gap != 0) begin
        pt_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (points_to_send.size() != 0) begin
        pt_valid <= 1'b1;
        pt_real <= points_to_send[0].re;
        pt_imag <= points_to_send[0].im;
        void'(points_to_send.pop_front());
        send_gap <= sender_idle_en ? pick_gap() : 0;
      end else begin
        pt_valid <= 1'b0;
      end
    end
  end

  // result receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      recv_hold <= 0;
      holds_done <= 0;
    end else if (recv_hold != 0) begin
      res_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else if (holds_done != hold_requests) begin
      res_ready <= 1'b0;
      holds_done <= holds_done + 1;
      recv_hold <= LONG_HOLD;
    end else if (receiver_idle_en && $urandom_range(0, 99) < 25) begin
      res_ready <= 1'b0;
      recv_hold <= pick_gap();
    end else begin
      res_ready <= 1'b1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_ready && out_res.valid) begin
        if (escape_results_due.size() == 0) begin
          note_mismatch($sformatf("result with nothing pending: escaped=%0b count=%0d",
                                  out_res.escaped, out_res.iteration_count));
        end else begin
          due = escape_results_due.pop_front();
          points_checked++;
          if (due.res.escaped) escaped_seen++;
          else bounded_seen++;
          if (out_res.escaped !== due.res.escaped || out_res.iteration_count !== due.res.count)
            note_mismatch($sformatf(
              "point (%h,%h): expected escaped=%0b count=%0d, got escaped=%0b count=%0d",
              due.pt.re, due.pt.im, due.res.escaped, due.res.count,
              out_res.escaped, out_res.iteration_count));
        end
      end
      if (pt_valid && in_pt.ready) begin
        due.pt.re = pt_real;
        due.pt.im = pt_imag;
        due.res = predict_escape(due.pt);
        escape_results_due.push_back(due);
      end
      if ((pt_valid && in_pt.ready) || (res_ready && out_res.valid)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", idle_cycles);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int k;
    logic [MAX_ITER_W-1:0] iters;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, Mandelbrot: bounded and escaping points, threshold equality and corners
    settings_used++;
    queue_point('0, '0);
    queue_point(-2 * Q_ONE, '0);
    queue_point(2 * Q_ONE, '0);
    queue_point(Q_ONE >>> 2, '0);
    queue_point(-Q_ONE, '0);
    queue_point('0, Q_ONE);
    queue_point(Q_ONE, '0);
    queue_point(-Q_LSB, -Q_LSB);
    queue_point(Q_MIN, Q_MIN);
    queue_point(Q_MAX, Q_MAX);
    queue_point(Q_MIN, Q_MAX);
    queue_point(Q_MAX, Q_MIN);
    wait_drained();

    // Julia with saturating constant, excess register bits
    settings_used++;
    write_reg(REG_JULIA_MODE, 32'hFFFF_FFFF);
    write_reg(REG_CONST_REAL, Q_MIN);
    write_reg(REG_CONST_IMAG, Q_MAX);
    write_reg(REG_ESCAPE_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(REG_MAX_ITERATIONS, 32'hFFFF_0010);
    queue_point('0, '0);
    queue_point(Q_MAX, Q_MIN);
    queue_point(Q_LSB, -Q_LSB);
    wait_drained();

    // zero iteration limit, zero threshold, writes to unused indexes
    settings_used++;
    for (k = 1; k <= 3; k++) write_reg(REG_MAX_ITERATIONS + CFG_IDX_W'(k), $urandom());
    write_reg(REG_JULIA_MODE, '0);
    write_reg(REG_ESCAPE_THRESHOLD, '0);
    write_reg(REG_MAX_ITERATIONS, '0);
    queue_point('0, '0);
    queue_point(Q_MAX, Q_MAX);
    wait_drained();
    write_reg(REG_MAX_ITERATIONS, 1);
    queue_point('0, '0);
    queue_point(Q_LSB, '0);
    wait_drained();

    // largest iteration limit
    settings_used++;
    write_reg(REG_ESCAPE_THRESHOLD, THRESH_RESET);
    write_reg(REG_MAX_ITERATIONS, 32'h0000_FFFF);
    queue_point('0, '0);
    queue_point(32'sh0042_8F5C, '0);
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settings_used++;
      sender_idle_en = ($urandom_range(0, 3) != 0);
      receiver_idle_en = ($urandom_range(0, 3) != 0);
      write_reg(REG_JULIA_MODE, {31'($urandom()), 1'($urandom_range(0, 1))});
      write_reg(REG_CONST_REAL, random_coord(32'h0140_0000));
      write_reg(REG_CONST_IMAG, random_coord(32'h0140_0000));
      write_reg(REG_ESCAPE_THRESHOLD, {1'($urandom()), pick_threshold()});
      iters = (phase == PRESSURE_PHASE) ? MAX_ITER_W'($urandom_range(1, 6)) : pick_iterations();
      write_reg(REG_MAX_ITERATIONS, {16'($urandom()), iters});
      if ($urandom_range(0, 4) == 0)
        write_reg(REG_MAX_ITERATIONS + CFG_IDX_W'($urandom_range(1, 3)), $urandom());
      if (phase == PRESSURE_PHASE) begin
        sender_idle_en = 1'b0;
        hold_requests++;
      end
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // sender pauses until the block is empty
        if (phase % 4 == 1 && k == ITEMS_PER_PHASE / 2) wait_drained();
        queue_point(random_coord(32'h0240_0000), random_coord(32'h0240_0000));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += escape_results_due.size();

    $display("checked %0d points: %0d escaped, %0d bounded", points_checked, escaped_seen,
             bounded_seen);
    $display("over %0d register settings in Mandelbrot and Julia modes, %0d mismatches",
             settings_used, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
